// ===== rtl/core/vec3_pkg.sv =====
package vec3_pkg;

    // Field widths of one word.
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Internal widths: a full product, a lane value (difference of two
    // products), and the merged dot sum of three products.
    localparam int PROD_W = 2 * DATA_W;
    localparam int LANE_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd2;
    localparam logic [OP_W-1:0] OP_DOT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CROSS = 3'd4;

    // Control that travels down the pipeline next to the data.
    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
    } t_ctl;

endpackage

// ===== rtl/core/vec3_lane.sv =====
module vec3_lane (
    input  logic                                    i_clk,
    input  logic [vec3_pkg::OP_W-1:0]               i_op,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_a,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_b,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_s,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_c0a,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_c0b,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_c1a,
    input  logic signed [vec3_pkg::DATA_W-1:0]      i_c1b,
    output logic signed [vec3_pkg::LANE_W-1:0]      o_val
);
    import vec3_pkg::*;

    logic signed [DATA_W-1:0] mul0_a;
    logic signed [DATA_W-1:0] mul0_b;
    logic signed [PROD_W-1:0] n_p0;
    logic signed [PROD_W-1:0] n_p1;
    logic signed [DATA_W:0]   n_as;
    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [DATA_W:0]   r_as;
    logic [OP_W-1:0]          r_op;
    logic signed [LANE_W-1:0] n_val;
    logic signed [LANE_W-1:0] r_val;

    // The first multiplier serves scale, dot and the first cross term.
    always_comb begin
        mul0_a = i_a;
        mul0_b = i_b;
        if (i_op == OP_SCALE) begin
            mul0_b = i_s;
        end else if (i_op == OP_CROSS) begin
            mul0_a = i_c0a;
            mul0_b = i_c0b;
        end
    end

    assign n_p0 = PROD_W'(mul0_a) * PROD_W'(mul0_b);
    assign n_p1 = PROD_W'(i_c1a) * PROD_W'(i_c1b);
    assign n_as = (i_op == OP_SUB) ? ((DATA_W+1)'(i_a) - (DATA_W+1)'(i_b))
                                   : ((DATA_W+1)'(i_a) + (DATA_W+1)'(i_b));

    always_ff @(posedge i_clk) begin
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        r_as <= n_as;
        r_op <= i_op;
    end

    always_comb begin
        case (r_op)
            OP_ADD, OP_SUB: begin
                n_val = LANE_W'(r_as);
            end
            OP_SCALE, OP_DOT: begin
                n_val = LANE_W'(r_p0);
            end
            OP_CROSS: begin
                n_val = LANE_W'(r_p0) - LANE_W'(r_p1);
            end
            default: begin
                n_val = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// ===== rtl/core/vec3_merge.sv =====
module vec3_merge #(
    parameter int FRAC_BITS = vec3_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vec3_pkg::t_ctl                      i_ctl,
    input  logic signed [vec3_pkg::LANE_W-1:0]  i_x,
    input  logic signed [vec3_pkg::LANE_W-1:0]  i_y,
    input  logic signed [vec3_pkg::LANE_W-1:0]  i_z,
    output logic                                o_done,
    output logic signed [vec3_pkg::DATA_W-1:0]  o_x,
    output logic signed [vec3_pkg::DATA_W-1:0]  o_y,
    output logic signed [vec3_pkg::DATA_W-1:0]  o_z,
    output logic                                o_overflow
);
    import vec3_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // Returns {overflow, saturated value}.
    function automatic logic [DATA_W:0] sat(input logic signed [SUM_W-1:0] v);
        logic [DATA_W:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[DATA_W-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[DATA_W-1:0]};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

    logic signed [SUM_W-1:0] ext_x;
    logic signed [SUM_W-1:0] ext_y;
    logic signed [SUM_W-1:0] ext_z;
    logic signed [SUM_W-1:0] dot_sum;
    logic signed [SUM_W-1:0] sh_x;
    logic signed [SUM_W-1:0] sh_y;
    logic signed [SUM_W-1:0] sh_z;
    logic signed [SUM_W-1:0] sh_dot;
    logic [DATA_W:0]         s_x;
    logic [DATA_W:0]         s_y;
    logic [DATA_W:0]         s_z;
    logic signed [DATA_W-1:0] n_x;
    logic signed [DATA_W-1:0] n_y;
    logic signed [DATA_W-1:0] n_z;
    logic                    n_ovf;
    logic                    r_done;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_z;
    logic                    r_ovf;

    assign ext_x   = SUM_W'(i_x);
    assign ext_y   = SUM_W'(i_y);
    assign ext_z   = SUM_W'(i_z);
    assign dot_sum = ext_x + ext_y + ext_z;

    // Arithmetic shift rounds toward negative infinity.
    assign sh_x   = ext_x >>> FRAC_BITS;
    assign sh_y   = ext_y >>> FRAC_BITS;
    assign sh_z   = ext_z >>> FRAC_BITS;
    assign sh_dot = dot_sum >>> FRAC_BITS;

    always_comb begin
        s_x = '0;
        s_y = '0;
        s_z = '0;
        case (i_ctl.op)
            OP_ADD, OP_SUB: begin
                s_x = sat(ext_x);
                s_y = sat(ext_y);
                s_z = sat(ext_z);
            end
            OP_SCALE, OP_CROSS: begin
                s_x = sat(sh_x);
                s_y = sat(sh_y);
                s_z = sat(sh_z);
            end
            OP_DOT: begin
                s_x = sat(sh_dot);
            end
            default: begin
                s_x = '0;
            end
        endcase
        n_x   = s_x[DATA_W-1:0];
        n_y   = s_y[DATA_W-1:0];
        n_z   = s_z[DATA_W-1:0];
        n_ovf = s_x[DATA_W] | s_y[DATA_W] | s_z[DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_ovf <= n_ovf;
    end

    assign o_done     = r_done;
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_z        = r_z;
    assign o_overflow = r_ovf;

endmodule

// ===== rtl/core/vector3_alu_core.sv =====
// Three-component vector ALU on signed fixed-point words (Q16.16 by default,
// FRAC_BITS fraction bits). A word is taken at every rising edge with i_start
// high and o_busy low; o_busy is high only while reset is applied and until
// the run flag is set, so a new word may follow in every cycle. Each word
// yields exactly one result, shown on the o_result_* ports and o_overflow for
// one cycle with o_done high once the word has passed the pipeline; results
// leave in the order the words came in. The receiver cannot stall the block,
// so it must take every result in the cycle o_done is high. Operations are
// add, subtract, scale of A by the scalar, dot product (in o_result_x, with
// the other components zero) and cross product; unused opcodes return all
// zeros. Products are rounded toward negative infinity, each component
// saturates to the 32-bit range, and o_overflow reports any saturation.
// Three lanes, one per component, each hold two 32x32 multipliers and a
// 33-bit adder; the pipeline has one multiply stage, one lane combine
// stage and one merge stage that sums the dot terms, rounds and saturates.
module vector3_alu_core #(
    parameter int FRAC_BITS = vec3_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [vec3_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_a_x,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_a_y,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_a_z,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_b_x,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_b_y,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_b_z,
    input  logic signed [vec3_pkg::DATA_W-1:0]  i_scale_factor,
    output logic                                o_done,
    output logic signed [vec3_pkg::DATA_W-1:0]  o_result_x,
    output logic signed [vec3_pkg::DATA_W-1:0]  o_result_y,
    output logic signed [vec3_pkg::DATA_W-1:0]  o_result_z,
    output logic                                o_overflow
);
    import vec3_pkg::*;

    logic                     r_run;
    logic                     accept;
    t_ctl                     n_ctl1;
    t_ctl                     r_ctl1;
    t_ctl                     r_ctl2;
    logic signed [LANE_W-1:0] lane_x;
    logic signed [LANE_W-1:0] lane_y;
    logic signed [LANE_W-1:0] lane_z;

    // The block leaves reset only once the run register is set, so that no
    // word is taken while the pipeline control is being cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign o_busy = ~r_run;
    assign accept = i_start & r_run;

    // Valid and opcode follow the data through the multiply and combine
    // stages; the lanes keep their own copy of the opcode for selection.
    always_comb begin
        n_ctl1.valid = accept;
        n_ctl1.op    = i_opcode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
        end
    end

    // Each lane forms one component. For the cross product the lane gets
    // the two operand pairs whose products it subtracts.
    vec3_lane u_lane_x (
        .i_clk (i_clk),
        .i_op  (i_opcode),
        .i_a   (i_a_x),
        .i_b   (i_b_x),
        .i_s   (i_scale_factor),
        .i_c0a (i_a_y),
        .i_c0b (i_b_z),
        .i_c1a (i_a_z),
        .i_c1b (i_b_y),
        .o_val (lane_x)
    );

    vec3_lane u_lane_y (
        .i_clk (i_clk),
        .i_op  (i_opcode),
        .i_a   (i_a_y),
        .i_b   (i_b_y),
        .i_s   (i_scale_factor),
        .i_c0a (i_a_z),
        .i_c0b (i_b_x),
        .i_c1a (i_a_x),
        .i_c1b (i_b_z),
        .o_val (lane_y)
    );

    vec3_lane u_lane_z (
        .i_clk (i_clk),
        .i_op  (i_opcode),
        .i_a   (i_a_z),
        .i_b   (i_b_z),
        .i_s   (i_scale_factor),
        .i_c0a (i_a_x),
        .i_c0b (i_b_y),
        .i_c1a (i_a_y),
        .i_c1b (i_b_x),
        .o_val (lane_z)
    );

    // The merge stage adds the dot terms, rounds, saturates and registers
    // the result word.
    vec3_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl2),
        .i_x        (lane_x),
        .i_y        (lane_y),
        .i_z        (lane_z),
        .o_done     (o_done),
        .o_x        (o_result_x),
        .o_y        (o_result_y),
        .o_z        (o_result_z),
        .o_overflow (o_overflow)
    );

    // A result only ever appears for an accepted word.
    a_done_from_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3)
    ) else $error("result strobe without a matching accepted word");

    // A dot product clears the y and z components.
    a_dot_zero_yz: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl2.valid && r_ctl2.op == OP_DOT) |=>
            (o_done && o_result_y == '0 && o_result_z == '0)
    ) else $error("dot product left nonzero y or z");

    // An unused opcode gives an all-zero result without overflow.
    a_unused_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl2.valid && r_ctl2.op != OP_ADD && r_ctl2.op != OP_SUB &&
         r_ctl2.op != OP_SCALE && r_ctl2.op != OP_DOT && r_ctl2.op != OP_CROSS) |=>
            (o_done && !o_overflow && o_result_x == '0 &&
             o_result_y == '0 && o_result_z == '0)
    ) else $error("unused opcode produced a nonzero result");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import vec3_pkg::*;

    // The block runs with its default fraction width, and the predictor
    // shifts its products by the same amount.
    localparam int FRAC = FRAC_BITS_DEF;

    // Opcodes above the cross product are unused and must give all zeros.
    localparam int OP_CODES = 1 << OP_W;

    // The run is stopped here if results stop coming.
    localparam int CYCLE_LIMIT = 100000;

    // Cycles that the end of the run waits after the last result for
    // any stray word.
    localparam int SETTLE_CYCLES = 8;

    typedef logic signed [DATA_W-1:0] t_q;
    // Wide enough for the exact sum of three full-width products.
    typedef logic signed [79:0] t_wide;

    localparam t_q MAX_Q = 32'sh7FFF_FFFF;
    localparam t_q MIN_Q = 32'sh8000_0000;
    localparam t_q ONE_Q = 32'sh0001_0000;

    typedef struct {
        logic [OP_W-1:0] op;
        t_q              a [3];
        t_q              b [3];
        t_q              scale;
    } t_alu_word;

    typedef struct {
        t_q   x;
        t_q   y;
        t_q   z;
        logic ovf;
    } t_alu_result;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_start        = 1'b0;
    logic [OP_W-1:0] i_opcode       = '0;
    t_q              i_a_x          = '0;
    t_q              i_a_y          = '0;
    t_q              i_a_z          = '0;
    t_q              i_b_x          = '0;
    t_q              i_b_y          = '0;
    t_q              i_b_z          = '0;
    t_q              i_scale_factor = '0;
    logic            o_busy;
    logic            o_done;
    t_q              o_result_x;
    t_q              o_result_y;
    t_q              o_result_z;
    logic            o_overflow;

    // Results the block still owes, oldest first.
    t_alu_result pending_results [$];
    t_alu_result expected_word;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // Sender pacing: words go out in bursts, and a gap with the start line
    // low follows each burst. Pacing can be switched off for a run at full rate.
    int   burst_left = 0;
    logic pacing_on  = 1'b1;

    vector3_alu_core #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_opcode      (i_opcode),
        .i_a_x         (i_a_x),
        .i_a_y         (i_a_y),
        .i_a_z         (i_a_z),
        .i_b_x         (i_b_x),
        .i_b_y         (i_b_y),
        .i_b_z         (i_b_z),
        .i_scale_factor(i_scale_factor),
        .o_done        (o_done),
        .o_result_x    (o_result_x),
        .o_result_y    (o_result_y),
        .o_result_z    (o_result_z),
        .o_overflow    (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a run that hangs is a failed run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_wide mul_wide(input t_q x, input t_q y);
        return t_wide'(x) * t_wide'(y);
    endfunction

    // Returns the saturation flag above the clipped 32-bit value.
    function automatic logic [DATA_W:0] saturate_q(input t_wide v);
        if (v > t_wide'(MAX_Q))
            return {1'b1, MAX_Q};
        if (v < t_wide'(MIN_Q))
            return {1'b1, MIN_Q};
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    // Every product and every sum is formed exactly at 80 bits. An
    // arithmetic right shift of a signed value is a floor division, which
    // is the rounding toward negative infinity the block must show.
    function automatic t_alu_result predict_alu(input t_alu_word w);
        t_wide           lane [3];
        t_q              comp [3];
        logic [DATA_W:0] clip;
        t_alu_result     r;
        lane = '{default: '0};
        r.ovf = 1'b0;
        case (w.op)
            OP_ADD: begin
                for (int i = 0; i < 3; i++)
                    lane[i] = t_wide'(w.a[i]) + t_wide'(w.b[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++)
                    lane[i] = t_wide'(w.a[i]) - t_wide'(w.b[i]);
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++)
                    lane[i] = mul_wide(w.a[i], w.scale) >>> FRAC;
            end
            OP_DOT: begin
                // One shift of the exact three-term sum; y and z stay zero.
                lane[0] = (mul_wide(w.a[0], w.b[0]) + mul_wide(w.a[1], w.b[1])
                           + mul_wide(w.a[2], w.b[2])) >>> FRAC;
            end
            OP_CROSS: begin
                lane[0] = (mul_wide(w.a[1], w.b[2]) - mul_wide(w.a[2], w.b[1])) >>> FRAC;
                lane[1] = (mul_wide(w.a[2], w.b[0]) - mul_wide(w.a[0], w.b[2])) >>> FRAC;
                lane[2] = (mul_wide(w.a[0], w.b[1]) - mul_wide(w.a[1], w.b[0])) >>> FRAC;
            end
            default: begin
                // Unused opcodes leave every lane at zero.
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            clip = saturate_q(lane[i]);
            r.ovf |= clip[DATA_W];
            comp[i] = clip[DATA_W-1:0];
        end
        r.x = comp[0];
        r.y = comp[1];
        r.z = comp[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drives one word and holds it until the block takes it. Inputs only
    // change at rising edges, so o_busy read at the falling edge is the
    // value the next rising edge sees. The start line is left high, so a
    // word that follows at once never sees it dropped in between.
    task automatic send_word(input t_alu_word w);
        i_start        <= 1'b1;
        i_opcode       <= w.op;
        i_a_x          <= w.a[0];
        i_a_y          <= w.a[1];
        i_a_z          <= w.a[2];
        i_b_x          <= w.b[0];
        i_b_y          <= w.b[1];
        i_b_z          <= w.b[2];
        i_scale_factor <= w.scale;
        do @(negedge i_clk); while (o_busy !== 1'b0);
        @(posedge i_clk);
        pending_results.push_back(predict_alu(w));
    endtask

    // Ends a burst with a gap of random length. Gaps of varied length put
    // idle cycles on each pipeline stage.
    task automatic pace_sender();
        if (!pacing_on)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        i_start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
        burst_left = $urandom_range(0, 20);
    endtask

    // Holds the sender off until every word in flight has come back. With
    // nothing in flight a gap has already dropped the start line.
    task automatic drain_results();
        if (pending_results.size() == 0)
            return;
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_alu_word make_word(input logic [OP_W-1:0] op,
                                            input t_q ax, input t_q ay, input t_q az,
                                            input t_q bx, input t_q by, input t_q bz,
                                            input t_q sf);
        t_alu_word w;
        w.op    = op;
        w.a     = '{ax, ay, az};
        w.b     = '{bx, by, bz};
        w.scale = sf;
        return w;
    endfunction

    // Mixes full-range values (which mostly saturate the products) with
    // small and medium ones that keep results in range, plus the corners.
    function automatic t_q pick_component();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_q'($urandom);
            4, 5:       return t_q'($urandom_range(0, 32'h000F_FFFF)) - t_q'(32'h0008_0000);
            6: begin
                case ($urandom_range(0, 4))
                    0:       return MAX_Q;
                    1:       return MIN_Q;
                    2:       return '0;
                    3:       return -t_q'(1);
                    default: return ONE_Q;
                endcase
            end
            default:    return t_q'($urandom) >>> $urandom_range(4, 24);
        endcase
    endfunction

    function automatic t_alu_word random_word();
        t_alu_word w;
        // About one word in twenty carries an unused opcode.
        if ($urandom_range(0, 19) == 0)
            w.op = OP_W'($urandom_range(OP_CROSS + 1, OP_CODES - 1));
        else
            w.op = OP_W'($urandom_range(0, OP_CROSS));
        for (int i = 0; i < 3; i++) begin
            w.a[i] = pick_component();
            w.b[i] = pick_component();
        end
        w.scale = pick_component();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input t_q want, input t_q got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // The result is stable in the middle of its one valid cycle, so it is
    // read at the falling edge and compared with the oldest expectation.
    always @(negedge i_clk) begin
        if (o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                mismatch_count++;
            end else begin
                expected_word = pending_results.pop_front();
                check_field("result_x", expected_word.x, o_result_x);
                check_field("result_y", expected_word.y, o_result_y);
                check_field("result_z", expected_word.z, o_result_z);
                check_field("overflow", t_q'(expected_word.ovf), t_q'(o_overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Sums and differences at the corners: both saturation directions,
    // exact results that just fit, and equal operands.
    task automatic test_add_sub();
        send_word(make_word(OP_ADD, MAX_Q, MIN_Q, ONE_Q, MAX_Q, MIN_Q, -ONE_Q, '0));
        send_word(make_word(OP_ADD, ONE_Q, -t_q'(1), 12345, -ONE_Q, 1, MIN_Q, '0));
        send_word(make_word(OP_ADD, MAX_Q, MIN_Q, '0, MIN_Q, MAX_Q, '0, MAX_Q));
        send_word(make_word(OP_SUB, MIN_Q, MAX_Q, '0, MAX_Q, MIN_Q, MIN_Q, '0));
        send_word(make_word(OP_SUB, -t_q'(1), MAX_Q, ONE_Q, MAX_Q, MAX_Q, ONE_Q, MIN_Q));
    endtask

    // Scaling: full-range products that saturate, the identity and zero
    // scalars, and tiny negative products that must round down to -1.
    task automatic test_scale();
        send_word(make_word(OP_SCALE, MAX_Q, MIN_Q, -t_q'(1), '0, '0, '0, MAX_Q));
        send_word(make_word(OP_SCALE, MIN_Q, MIN_Q, 1, MAX_Q, '0, '0, MIN_Q));
        send_word(make_word(OP_SCALE, -t_q'(1), 1, ONE_Q, '0, '0, '0, 1));
        send_word(make_word(OP_SCALE, MAX_Q, MIN_Q, -12345, '0, '0, '0, ONE_Q));
        send_word(make_word(OP_SCALE, MIN_Q, MAX_Q, 777, '0, '0, '0, -ONE_Q));
        send_word(make_word(OP_SCALE, MAX_Q, MIN_Q, ONE_Q, MAX_Q, MIN_Q, ONE_Q, '0));
    endtask

    // Dot products: a sum beyond 64 bits, huge terms that cancel to a small
    // negative value, a one-ulp negative result, and plain unit vectors.
    task automatic test_dot();
        send_word(make_word(OP_DOT, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MAX_Q));
        send_word(make_word(OP_DOT, MAX_Q, MIN_Q, '0, MAX_Q, MAX_Q, MIN_Q, '0));
        send_word(make_word(OP_DOT, -t_q'(1), '0, '0, 1, MAX_Q, MAX_Q, '0));
        send_word(make_word(OP_DOT, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, MIN_Q));
    endtask

    // Cross products: all-corner operands, two huge products whose
    // difference just fits, unit axes, and one-ulp components.
    task automatic test_cross();
        send_word(make_word(OP_CROSS, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q, '0));
        send_word(make_word(OP_CROSS, '0, MIN_Q, MAX_Q, '0, MAX_Q, MIN_Q, '0));
        send_word(make_word(OP_CROSS, ONE_Q, '0, '0, '0, ONE_Q, '0, MAX_Q));
        send_word(make_word(OP_CROSS, -t_q'(1), 1, -t_q'(1), 1, 1, -t_q'(1), '0));
    endtask

    // Unused opcodes with busy operands must still produce all zeros.
    task automatic test_unused_opcodes();
        t_alu_word w;
        for (int c = OP_CROSS + 1; c < OP_CODES; c++) begin
            w = make_word(OP_W'(c), MIN_Q, MAX_Q, -t_q'(1), MAX_Q, MIN_Q, ONE_Q, MIN_Q);
            send_word(w);
        end
    endtask

    // The bulk of the run: bursts with random gaps, then a stretch at the
    // full one-word-per-cycle rate, and a hold-off until the pipeline is
    // empty two thirds of the way through.
    task automatic test_random_stream(input int count);
        for (int k = 0; k < count; k++) begin
            if (k == count / 3)
                pacing_on = 1'b0;
            if (k == count / 3 + 150)
                pacing_on = 1'b1;
            if (k == (2 * count) / 3)
                drain_results();
            send_word(random_word());
            pace_sender();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_add_sub();
        test_scale();
        drain_results();
        test_dot();
        test_cross();
        test_unused_opcodes();
        test_random_stream(950);

        // Let everything in flight come back, then give a stray word time
        // to show up before the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/vec3_pkg.sv
rtl/core/vec3_lane.sv
rtl/core/vec3_merge.sv
rtl/core/vector3_alu_core.sv
bench/tb_top.sv
